FILE: sv/fpmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmd_pkg: shared types and constants of the fixed-point MAC/divide unit
// Opcodes, status codes, widths and the result-finish control bundle.
// ----------------------------------------------------------------------------
package fpmd_pkg;
	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int FMAC_SHIFT = 15;
	localparam int FMAC_WIDTH = 16;
	localparam int NUM_LANES = 4;
	// product 64 bits, sum of four products 66, numerator shifted up to 2*WORD
	localparam int ACC_BITS = 2 * WORD_BITS + 3;
	localparam int NUM_BITS = 2 * WORD_BITS + 2;
	localparam int DEN_BITS = WORD_BITS;

	typedef enum logic [4:0] {
		OP_ABS = 5'd0, OP_MUL = 5'd1, OP_DIV = 5'd2, OP_DIVR = 5'd3, OP_RECIP = 5'd4,
		OP_SQ1 = 5'd5, OP_SQ2 = 5'd6, OP_SQ3 = 5'd7, OP_SQ4 = 5'd8,
		OP_MAC2 = 5'd9, OP_MAC3 = 5'd10, OP_MAC4 = 5'd11, OP_MULDIV = 5'd12,
		OP_MD2 = 5'd13, OP_MD3 = 5'd14, OP_MD4 = 5'd15,
		OP_FMAC2 = 5'd16, OP_FMAC3 = 5'd17, OP_FMAC4 = 5'd18
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	// how the merged value is finished
	typedef enum logic [1:0] {
		FIN_ZERO = 2'd0, FIN_SHIFT = 2'd1, FIN_DIV = 2'd2
	} fin_t;

	typedef struct packed {
		fin_t fin;
		logic fmac;   // shift by FMAC_SHIFT instead of FRAC_BITS
	} ctl_t;
endpackage

FILE: sv/fixed_point_mac_divide_unit_top.sv
`timescale 1ns / 1ps
// A transaction passes stage 1, the merge stage, the divider or its delay line, and the result register.
// Throughput: one transaction per cycle; the whole pipeline stalls while out_valid and out_stall are both high.
// All modes go through the same pipeline depth, set by the divider's register stages.
// Reset (arst_n low) clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// fixed_point_mac_divide_unit_top: 16.16 multiply/accumulate/divide unit
// Four multiplier lanes, merge adder, divider pipeline and result wrap check.
// ----------------------------------------------------------------------------
module fixed_point_mac_divide_unit_top import fpmd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [4:0]                  mode,
	input  logic signed [31:0]          x0, x1, x2, x3, x4, x5, x6, x7,
	input  logic signed [31:0]          divisor,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          result,
	output logic [1:0]                  status
);
	localparam int DIV_REGS = NUM_BITS / 4 + 1;
	localparam int DEPTH = 2 + DIV_REGS + 1;

	logic en;
	logic [DEPTH-1:0] vld_q;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	logic signed [WORD_BITS-1:0] op [9];
	logic signed [WORD_BITS-1:0] fr [4];
	always_comb begin
		op[0] = WORD_BITS'(x0); op[1] = WORD_BITS'(x1); op[2] = WORD_BITS'(x2);
		op[3] = WORD_BITS'(x3); op[4] = WORD_BITS'(x4); op[5] = WORD_BITS'(x5);
		op[6] = WORD_BITS'(x6); op[7] = WORD_BITS'(x7); op[8] = WORD_BITS'(divisor);
		fr[0] = WORD_BITS'($signed(x0[FMAC_WIDTH-1:0]));
		fr[1] = WORD_BITS'($signed(x2[FMAC_WIDTH-1:0]));
		fr[2] = WORD_BITS'($signed(x4[FMAC_WIDTH-1:0]));
		fr[3] = WORD_BITS'($signed(x6[FMAC_WIDTH-1:0]));
	end

	// ---- decode ----
	logic signed [WORD_BITS-1:0] la [NUM_LANES];
	logic signed [WORD_BITS-1:0] lb [NUM_LANES];
	logic [NUM_LANES-1:0]        luse;
	ctl_t                        ctl;
	logic                        is_div, is_abs, is_recip, is_divr;
	always_comb begin
		luse = '0; ctl = '{fin: FIN_ZERO, fmac: 1'b0};
		is_div = 1'b0; is_abs = 1'b0; is_recip = 1'b0; is_divr = 1'b0;
		for (int k = 0; k < NUM_LANES; k++) begin
			la[k] = op[2*k]; lb[k] = op[2*k+1];
		end
		case (mode)
			OP_ABS: begin is_abs = 1'b1; ctl.fin = FIN_SHIFT; end
			OP_MUL: begin luse = 4'b0001; ctl.fin = FIN_SHIFT; end
			OP_DIV: begin is_div = 1'b1; ctl.fin = FIN_DIV; end
			OP_DIVR: begin is_div = 1'b1; is_divr = 1'b1; ctl.fin = FIN_DIV; end
			OP_RECIP: begin is_recip = 1'b1; ctl.fin = FIN_DIV; end
			OP_SQ1, OP_SQ2, OP_SQ3, OP_SQ4: begin
				for (int k = 0; k < NUM_LANES; k++) begin
					la[k] = op[k]; lb[k] = op[k];
					luse[k] = (k < 32'(mode - OP_SQ1) + 1);
				end
				ctl.fin = FIN_SHIFT;
			end
			OP_MAC2, OP_MAC3, OP_MAC4: begin
				for (int k = 0; k < NUM_LANES; k++)
					luse[k] = (k < 32'(mode - OP_MAC2) + 2);
				ctl.fin = FIN_SHIFT;
			end
			OP_MULDIV: begin luse = 4'b0001; ctl.fin = FIN_DIV; end
			OP_MD2, OP_MD3, OP_MD4: begin
				for (int k = 0; k < NUM_LANES; k++)
					luse[k] = (k < 32'(mode - OP_MD2) + 2);
				ctl.fin = FIN_DIV;
			end
			OP_FMAC2, OP_FMAC3, OP_FMAC4: begin
				for (int k = 0; k < NUM_LANES; k++) begin
					la[k] = fr[k];
					luse[k] = (k < 32'(mode - OP_FMAC2) + 2);
				end
				ctl.fin = FIN_SHIFT; ctl.fmac = 1'b1;
			end
			default: ;
		endcase
	end

	// ---- stage 1: lanes, plus direct numerator for abs / div / recip ----
	logic signed [2*WORD_BITS-1:0] prod_s1 [NUM_LANES];
	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		fpmd_lane u_lane (
			.clk(clk), .en(en), .use_lane(luse[k]),
			.a(la[k]), .b(lb[k]), .prod_s1(prod_s1[k])
		);
	end

	logic signed [ACC_BITS-1:0] dir_s1;
	logic                       dir_use_s1;
	logic signed [DEN_BITS-1:0] den_s1;
	ctl_t                       ctl_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1     <= ctl;
			dir_use_s1 <= is_abs | is_div | is_recip;
			// abs rides the shift path, so it is scaled up by the same amount
			if (is_abs)
				dir_s1 <= (op[0][WORD_BITS-1] ? -ACC_BITS'(op[0]) : ACC_BITS'(op[0]))
				        <<< FRAC_BITS;
			else if (is_recip)
				dir_s1 <= ACC_BITS'(1) <<< (2*FRAC_BITS);
			else
				dir_s1 <= (ACC_BITS'(op[0]) <<< FRAC_BITS)
				        + (is_divr ? ACC_BITS'(op[1] >>> 1) : '0);
			den_s1 <= is_recip ? op[0] : (is_div ? op[1] : op[8]);
		end
	end

	// ---- stage 2: merge ----
	logic signed [ACC_BITS-1:0] acc_s2;
	logic signed [DEN_BITS-1:0] den_s2;
	ctl_t                       ctl_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			den_s2 <= den_s1;
			if (dir_use_s1)
				acc_s2 <= dir_s1;
			else
				acc_s2 <= ACC_BITS'(prod_s1[0]) + ACC_BITS'(prod_s1[1])
				        + ACC_BITS'(prod_s1[2]) + ACC_BITS'(prod_s1[3]);
		end
	end

	// ---- divider and aligned side path ----
	logic signed [NUM_BITS:0] quo;
	fpmd_div u_div (
		.clk(clk), .en(en), .num(NUM_BITS'(acc_s2)), .den(den_s2), .quo(quo)
	);

	logic signed [ACC_BITS-1:0] acc_d [DIV_REGS+1];
	ctl_t                       ctl_d [DIV_REGS+1];
	logic                       dz_d  [DIV_REGS+1];
	always_comb begin
		acc_d[0] = acc_s2; ctl_d[0] = ctl_s2; dz_d[0] = (den_s2 == '0);
	end
	for (genvar i = 0; i < DIV_REGS; i++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				acc_d[i+1] <= acc_d[i]; ctl_d[i+1] <= ctl_d[i]; dz_d[i+1] <= dz_d[i];
			end
		end
	end

	// ---- final stage: shift, quotient or zero, divide-by-zero and wrap check ----
	logic signed [ACC_BITS-1:0] val;
	ctl_t                       cf;
	always_comb begin
		cf = ctl_d[DIV_REGS];
		case (cf.fin)
			FIN_SHIFT: val = cf.fmac ? (acc_d[DIV_REGS] >>> FMAC_SHIFT)
			                         : (acc_d[DIV_REGS] >>> FRAC_BITS);
			FIN_DIV:   val = ACC_BITS'(quo);
			default:   val = '0;
		endcase
	end

	logic signed [31:0] result_q;
	logic [1:0]         status_q;
	always_ff @(posedge clk) begin
		if (en) begin
			if (cf.fin == FIN_DIV && dz_d[DIV_REGS]) begin
				result_q <= '0; status_q <= ST_DIV0;
			end else begin
				result_q <= 32'($signed(val[WORD_BITS-1:0]));
				status_q <= (val == ACC_BITS'($signed(val[WORD_BITS-1:0]))) ? ST_OK : ST_OVF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[DEPTH-1];
	assign result    = result_q;
	assign status    = status_q;
endmodule

FILE: sv/fpmd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmd_lane: one multiplier lane
// Registered signed product of two operands, or zero when the lane is unused.
// ----------------------------------------------------------------------------
module fpmd_lane import fpmd_pkg::*; (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          use_lane,
	input  logic signed [WORD_BITS-1:0]   a,
	input  logic signed [WORD_BITS-1:0]   b,
	output logic signed [2*WORD_BITS-1:0] prod_s1
);
	always_ff @(posedge clk) begin
		if (en) begin
			// keep the product in a signed-only expression
			if (use_lane)
				prod_s1 <= a * b;
			else
				prod_s1 <= '0;
		end
	end
endmodule

FILE: sv/fpmd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmd_div: pipelined restoring divider
// One quotient bit per stage, magnitudes, sign applied at the end.
// ----------------------------------------------------------------------------
module fpmd_div import fpmd_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [NUM_BITS-1:0] num,
	input  logic signed [DEN_BITS-1:0] den,
	output logic signed [NUM_BITS:0]   quo
);
	localparam int N = NUM_BITS;
	logic [N-1:0]          q_r   [N+1];
	logic [N-1:0]          n_r   [N+1];
	logic [DEN_BITS:0]     r_r   [N+1];
	logic [DEN_BITS:0]     d_r   [N+1];
	logic                  neg_r [N+1];
	logic signed [N:0]     quo_q;

	always_comb begin
		n_r[0]   = num[N-1] ? N'(-num) : N'(num);
		d_r[0]   = den[DEN_BITS-1] ? (DEN_BITS+1)'(-{den[DEN_BITS-1], den})
		                           : {1'b0, den};
		r_r[0]   = '0;
		q_r[0]   = '0;
		neg_r[0] = num[N-1] ^ den[DEN_BITS-1];
	end

	// register every fourth stage so up to four subtracts sit between registers
	for (genvar i = 0; i < N; i++) begin : g_st
		logic [DEN_BITS+1:0] t;
		logic [DEN_BITS:0]   r_n;
		logic [N-1:0]        q_n, n_n;
		always_comb begin
			t   = {r_r[i], n_r[i][N-1]};
			n_n = n_r[i] << 1;
			if (t >= {1'b0, d_r[i]}) begin
				r_n = (DEN_BITS+1)'(t - {1'b0, d_r[i]});
				q_n = {q_r[i][N-2:0], 1'b1};
			end else begin
				r_n = t[DEN_BITS:0];
				q_n = {q_r[i][N-2:0], 1'b0};
			end
		end
		if (i % 4 == 3) begin : g_reg
			always_ff @(posedge clk) begin
				if (en) begin
					r_r[i+1] <= r_n; q_r[i+1] <= q_n; n_r[i+1] <= n_n;
					d_r[i+1] <= d_r[i]; neg_r[i+1] <= neg_r[i];
				end
			end
		end else begin : g_cmb
			assign r_r[i+1] = r_n;
			assign q_r[i+1] = q_n;
			assign n_r[i+1] = n_n;
			assign d_r[i+1] = d_r[i];
			assign neg_r[i+1] = neg_r[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= neg_r[N] ? -$signed({1'b0, q_r[N]}) : $signed({1'b0, q_r[N]});
		end
	end
	assign quo = quo_q;
endmodule

FILE: sv/fpmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmd_checker: port-level checks for the MAC/divide unit
// Handshake and status encoding rules seen at the top-level ports.
// ----------------------------------------------------------------------------
module fpmd_checker import fpmd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result,
	input logic [1:0]  status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(status))
		else $error("stalled result changed");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status code");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIV0 |-> result == '0) else $error("div0 result nonzero");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall) else $error("input stalled without cause");
endmodule

bind fixed_point_mac_divide_unit_top fpmd_checker u_fpmd_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .result(result), .status(status)
);
